// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the buddy page allocator
// Widths, opcodes, frame flag codes and the sequencer-to-memory bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
   localparam int MAX_FRAMES = 4096;
   localparam int LEVELS     = 11;
   localparam int PAGE_BYTES = 4096;
   localparam int IDX_W  = $clog2(MAX_FRAMES);
   localparam int CNT_W  = 13;
   localparam int LVL_W  = 4;
   localparam int PG_SH  = $clog2(PAGE_BYTES);
   localparam int HEAD_W = $clog2(LEVELS);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;

   localparam logic [1:0] FL_ALLOC = 2'd1;
   localparam logic [1:0] FL_HEAD  = 2'd2;
   localparam logic [1:0] FL_AHEAD = 2'd3;

   // Configuration register indexes
   localparam logic [0:0] REG_FRAMES_COUNT = 1'b0;
   localparam logic [0:0] REG_REGION_BASE  = 1'b1;

   typedef struct packed {
      logic             wr;
      logic [IDX_W-1:0] waddr;
      logic             wr_level;
      logic [LVL_W-1:0] level;
      logic             wr_flags;
      logic [1:0]       flags;
      logic             wr_next;
      logic [CNT_W-1:0] next;
      logic             wr_prev;
      logic [CNT_W-1:0] prev;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic [1:0]       flags;
      logic [CNT_W-1:0] next;
      logic [CNT_W-1:0] prev;
   } mem_rsp_type;
endpackage
`default_nettype wire

// ===== src/bpa_if.sv =====
// ----------------------------------------------------------------------------
// bpa_req_if / bpa_rsp_if: valid/ready channels of the allocator
// Request carries op, size and address; response carries the outcome.
// ----------------------------------------------------------------------------
`default_nettype none
interface bpa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] nbytes;
   logic [31:0] address;
   modport source (output valid, op, nbytes, address, input ready);
   modport sink   (input valid, op, nbytes, address, output ready);
endinterface

interface bpa_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [31:0] block_address;
   logic [3:0]  blk_order;
   modport source (output valid, ok, block_address, blk_order, input ready);
   modport sink   (input valid, ok, block_address, blk_order, output ready);
endinterface
`default_nettype wire

// ===== src/bpa_frame_mem.sv =====
// ----------------------------------------------------------------------------
// bpa_frame_mem: per-frame level, flags and list links
// One write port and one registered read port per field.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_frame_mem (
   input  wire                        clock,
   input  wire bpa_pkg::mem_req_type  req,
   output bpa_pkg::mem_rsp_type       rsp
);
   logic [bpa_pkg::LVL_W-1:0] level_mem [bpa_pkg::MAX_FRAMES];
   logic [1:0]                flags_mem [bpa_pkg::MAX_FRAMES];
   logic [bpa_pkg::CNT_W-1:0] next_mem  [bpa_pkg::MAX_FRAMES];
   logic [bpa_pkg::CNT_W-1:0] prev_mem  [bpa_pkg::MAX_FRAMES];

   // Write selected fields, read all fields
   always_ff @(posedge clock) begin
      if (req.wr && req.wr_level) level_mem[req.waddr] <= req.level;
      if (req.wr && req.wr_flags) flags_mem[req.waddr] <= req.flags;
      if (req.wr && req.wr_next)  next_mem[req.waddr]  <= req.next;
      if (req.wr && req.wr_prev)  prev_mem[req.waddr]  <= req.prev;
      rsp.level <= level_mem[req.raddr];
      rsp.flags <= flags_mem[req.raddr];
      rsp.next  <= next_mem[req.raddr];
      rsp.prev  <= prev_mem[req.raddr];
   end
endmodule
`default_nettype wire

// ===== src/bpa_seq.sv =====
// ----------------------------------------------------------------------------
// bpa_seq: sequencer for init, allocate and free
// Walks the frame memory one access per cycle; holds the list heads.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_seq (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  [12:0]                frames_count,
   input  wire  [31:0]                region_base,
   bpa_req_if.sink                    req,
   bpa_rsp_if.source                  rsp,
   output bpa_pkg::mem_req_type       mreq,
   input  wire bpa_pkg::mem_rsp_type  mrsp
);
   localparam int CW = bpa_pkg::CNT_W;
   localparam int IW = bpa_pkg::IDX_W;
   localparam int LW = bpa_pkg::LVL_W;
   localparam logic [LW-1:0] TOP = LW'(bpa_pkg::LEVELS - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_INIT_CLR, S_INIT_BLK, S_PUSH, S_PUSH_PREV,
      S_AL_SCAN, S_AL_RD, S_AL_WAIT, S_AL_UNL, S_AL_UNL2, S_AL_SPLIT, S_AL_FIN,
      S_FR_RD, S_FR_WAIT, S_FR_CHK, S_FR_BWAIT, S_FR_BCHK, S_FR_UNL, S_FR_UNL2,
      S_FR_CLRB, S_DONE
   } state_type;

   state_type           state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0]       heads_ff [bpa_pkg::LEVELS];
   logic [CW-1:0]       heads_in [bpa_pkg::LEVELS];
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       bud_ff, bud_in;
   logic [CW-1:0]       pidx_ff, pidx_in;
   logic [CW-1:0]       p_ff, p_in, n_ff, n_in;
   logic [LW-1:0]       lvl_ff, lvl_in, cur_ff, cur_in, plvl_ff, plvl_in;
   logic [LW-1:0]       ulvl_ff, ulvl_in;
   logic [CW:0]         bsize_ff, bsize_in;
   logic [3:0]          blvl_ff, blvl_in;
   logic                ok_ff, ok_in, valid_ff, valid_in;
   logic [31:0]         addr_ff, addr_in;
   logic [LW-1:0]       olvl_ff, olvl_in;
   logic [20:0]         pages;
   logic [LW-1:0]       need;
   logic [31:0]         fidx;
   logic [CW-1:0]       old_head;

   assign req.ready         = (state_ff == S_IDLE) && !valid_ff;
   assign rsp.valid         = valid_ff;
   assign rsp.ok            = ok_ff;
   assign rsp.block_address = addr_ff;
   assign rsp.blk_order     = olvl_ff;

   // Page count and level needed for an allocate
   always_comb begin
      pages = 21'(req.nbytes >> bpa_pkg::PG_SH)
            + 21'(|req.nbytes[bpa_pkg::PG_SH-1:0]);
      if (pages == 21'd0) pages = 21'd1;
      need = LW'(bpa_pkg::LEVELS);
      for (int k = bpa_pkg::LEVELS - 1; k >= 0; k--)
         if ((21'd1 << k) >= pages) need = LW'(k);
      fidx = (req.address - region_base) >> bpa_pkg::PG_SH;
   end

   assign old_head = heads_ff[plvl_ff];

   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      heads_in = heads_ff; cnt_in = cnt_ff; idx_in = idx_ff; bud_in = bud_ff;
      pidx_in = pidx_ff; p_in = p_ff; n_in = n_ff; lvl_in = lvl_ff;
      cur_in = cur_ff; plvl_in = plvl_ff; ulvl_in = ulvl_ff;
      bsize_in = bsize_ff; blvl_in = blvl_ff; ok_in = ok_ff;
      valid_in = valid_ff; addr_in = addr_ff; olvl_in = olvl_ff;
      mreq = '0;
      if (valid_ff && rsp.ready) valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cnt_in = (frames_count > CW'(bpa_pkg::MAX_FRAMES))
                      ? CW'(bpa_pkg::MAX_FRAMES) : frames_count;
               ok_in = 1'b0; addr_in = '0; olvl_in = '0;
               unique case (req.op)
                  bpa_pkg::OP_INIT: begin
                     for (int k = 0; k < bpa_pkg::LEVELS; k++) heads_in[k] = cnt_in;
                     idx_in = '0;
                     state_in = (cnt_in == '0) ? S_DONE : S_INIT_CLR;
                     ok_in = 1'b1;
                  end
                  bpa_pkg::OP_ALLOC: begin
                     lvl_in = need; cur_in = need;
                     state_in = (need >= LW'(bpa_pkg::LEVELS)) ? S_DONE : S_AL_SCAN;
                  end
                  bpa_pkg::OP_FREE: begin
                     idx_in = CW'(fidx[IW-1:0]);
                     state_in = (fidx >= 32'(cnt_in)) ? S_DONE : S_FR_RD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // Mark every frame as inner allocated, unlinked
         S_INIT_CLR: begin
            mreq.wr = 1'b1; mreq.waddr = idx_ff[IW-1:0];
            mreq.wr_level = 1'b1; mreq.level = '0;
            mreq.wr_flags = 1'b1; mreq.flags = bpa_pkg::FL_ALLOC;
            mreq.wr_next = 1'b1; mreq.next = cnt_ff;
            mreq.wr_prev = 1'b1; mreq.prev = cnt_ff;
            idx_in = idx_ff + 1'b1;
            if (idx_in == cnt_ff) begin
               idx_in = '0; bsize_in = (CW+1)'(1) << (bpa_pkg::LEVELS - 1);
               blvl_in = TOP; state_in = S_INIT_BLK;
            end
         end
         // Pick the largest block that fits at idx
         S_INIT_BLK: begin
            if (idx_ff >= cnt_ff) state_in = S_DONE;
            else if ((CW+1)'(idx_ff) + bsize_ff > (CW+1)'(cnt_ff)) begin
               bsize_in = bsize_ff >> 1; blvl_in = blvl_ff - 1'b1;
            end else begin
               pidx_in = idx_ff; plvl_in = blvl_ff; ret_in = S_INIT_BLK;
               idx_in = idx_ff + CW'(bsize_ff); state_in = S_PUSH;
            end
         end
         // Push pidx onto list plvl
         S_PUSH: begin
            mreq.wr = 1'b1; mreq.waddr = pidx_ff[IW-1:0];
            mreq.wr_level = 1'b1; mreq.level = plvl_ff;
            mreq.wr_flags = 1'b1; mreq.flags = bpa_pkg::FL_HEAD;
            mreq.wr_next = 1'b1; mreq.next = (old_head < cnt_ff) ? old_head : cnt_ff;
            mreq.wr_prev = 1'b1; mreq.prev = cnt_ff;
            n_in = old_head;
            heads_in[plvl_ff] = pidx_ff;
            state_in = (old_head < cnt_ff) ? S_PUSH_PREV : ret_ff;
         end
         S_PUSH_PREV: begin
            mreq.wr = 1'b1; mreq.waddr = n_ff[IW-1:0];
            mreq.wr_prev = 1'b1; mreq.prev = pidx_ff;
            state_in = ret_ff;
         end
         // Find the smallest non-empty level
         S_AL_SCAN: begin
            if (cur_ff >= LW'(bpa_pkg::LEVELS)) state_in = S_DONE;
            else if (heads_ff[cur_ff] >= cnt_ff) cur_in = cur_ff + 1'b1;
            else begin
               idx_in = heads_ff[cur_ff]; state_in = S_AL_RD;
            end
         end
         S_AL_RD: begin
            mreq.raddr = idx_ff[IW-1:0]; state_in = S_AL_WAIT;
         end
         S_AL_WAIT: begin
            p_in = mrsp.prev; n_in = mrsp.next; ulvl_in = cur_ff;
            ret_in = S_AL_SPLIT; state_in = S_AL_UNL;
         end
         // Unlink: p/n hold links, ulvl the list
         S_AL_UNL, S_FR_UNL: begin
            if (p_ff >= cnt_ff) heads_in[ulvl_ff] = (n_ff < cnt_ff) ? n_ff : cnt_ff;
            else begin
               mreq.wr = 1'b1; mreq.waddr = p_ff[IW-1:0];
               mreq.wr_next = 1'b1; mreq.next = (n_ff < cnt_ff) ? n_ff : cnt_ff;
            end
            state_in = (n_ff < cnt_ff) ? ((state_ff == S_AL_UNL) ? S_AL_UNL2 : S_FR_UNL2)
                     : ((state_ff == S_AL_UNL) ? S_AL_SPLIT : S_FR_CLRB);
         end
         S_AL_UNL2, S_FR_UNL2: begin
            mreq.wr = 1'b1; mreq.waddr = n_ff[IW-1:0];
            mreq.wr_prev = 1'b1; mreq.prev = (p_ff < cnt_ff) ? p_ff : cnt_ff;
            state_in = (state_ff == S_AL_UNL2) ? S_AL_SPLIT : S_FR_CLRB;
         end
         // Split down, pushing upper halves
         S_AL_SPLIT: begin
            if (cur_ff > lvl_ff) begin
               cur_in = cur_ff - 1'b1;
               pidx_in = idx_ff ^ (CW'(1) << cur_in);
               plvl_in = cur_in; ret_in = S_AL_SPLIT;
               if (pidx_in < cnt_ff) state_in = S_PUSH;
            end else state_in = S_AL_FIN;
         end
         S_AL_FIN: begin
            mreq.wr = 1'b1; mreq.waddr = idx_ff[IW-1:0];
            mreq.wr_level = 1'b1; mreq.level = lvl_ff;
            mreq.wr_flags = 1'b1; mreq.flags = bpa_pkg::FL_AHEAD;
            mreq.wr_next = 1'b1; mreq.next = cnt_ff;
            mreq.wr_prev = 1'b1; mreq.prev = cnt_ff;
            ok_in = 1'b1; olvl_in = lvl_ff;
            addr_in = region_base + (32'(idx_ff) << bpa_pkg::PG_SH);
            state_in = S_DONE;
         end
         S_FR_RD: begin
            mreq.raddr = idx_ff[IW-1:0]; state_in = S_FR_WAIT;
         end
         // Hold the read address so the frame data is still valid at the check
         S_FR_WAIT: begin
            mreq.raddr = idx_ff[IW-1:0]; state_in = S_FR_CHK;
         end
         S_FR_CHK: begin
            if (mrsp.flags != bpa_pkg::FL_AHEAD) state_in = S_DONE;
            else begin
               lvl_in = (mrsp.level > TOP) ? TOP : mrsp.level;
               state_in = S_FR_BCHK; bud_in = cnt_ff;
               ok_in = 1'b0;
            end
         end
         // Try the buddy at level lvl
         S_FR_BCHK: begin
            bud_in = idx_ff ^ (CW'(1) << lvl_ff);
            if (lvl_ff >= TOP || bud_in >= cnt_ff) begin
               pidx_in = idx_ff; plvl_in = lvl_ff; ret_in = S_DONE;
               ok_in = 1'b1; olvl_in = lvl_ff; state_in = S_PUSH;
            end else begin
               mreq.raddr = bud_in[IW-1:0]; state_in = S_FR_BWAIT;
            end
         end
         S_FR_BWAIT: begin
            if (mrsp.level != lvl_ff || mrsp.flags != bpa_pkg::FL_HEAD) begin
               pidx_in = idx_ff; plvl_in = lvl_ff; ret_in = S_DONE;
               ok_in = 1'b1; olvl_in = lvl_ff; state_in = S_PUSH;
            end else begin
               p_in = mrsp.prev; n_in = mrsp.next; ulvl_in = lvl_ff;
               state_in = S_FR_UNL;
            end
         end
         S_FR_CLRB: begin
            mreq.wr = 1'b1;
            mreq.waddr = (bud_ff > idx_ff) ? bud_ff[IW-1:0] : idx_ff[IW-1:0];
            mreq.wr_level = 1'b1; mreq.level = '0;
            mreq.wr_flags = 1'b1; mreq.flags = bpa_pkg::FL_ALLOC;
            if (bud_ff < idx_ff) idx_in = bud_ff;
            lvl_in = lvl_ff + 1'b1; state_in = S_FR_BCHK;
         end
         S_DONE: begin
            if (!valid_ff) begin
               valid_in = 1'b1; state_in = S_IDLE;
               if (!ok_ff) begin addr_in = '0; olvl_in = '0; end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ret_ff <= S_IDLE; valid_ff <= 1'b0;
         for (int k = 0; k < bpa_pkg::LEVELS; k++) heads_ff[k] <= CW'(bpa_pkg::MAX_FRAMES);
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; valid_ff <= valid_in;
         heads_ff <= heads_in;
      end
      cnt_ff <= cnt_in; idx_ff <= idx_in; bud_ff <= bud_in; pidx_ff <= pidx_in;
      p_ff <= p_in; n_ff <= n_in; lvl_ff <= lvl_in; cur_ff <= cur_in;
      plvl_ff <= plvl_in; ulvl_ff <= ulvl_in; bsize_ff <= bsize_in;
      blvl_ff <= blvl_in; ok_ff <= ok_in; addr_ff <= addr_in; olvl_ff <= olvl_in;
   end
endmodule
`default_nettype wire

// ===== src/buddy_page_allocator_top.sv =====
// Steps, accept to response: allocate scans levels, reads, unlinks, then pushes
//   an upper half per split level; free reads and checks the frame, then per
//   merge level reads, unlinks and clears the buddy; initialize clears each frame.
// Throughput: one item in flight; ready returns once the response is taken.
// Reset: list heads empty, frames_count 4096, region_base 0; frame memory
//   is not cleared and must be built by an initialize.
// ----------------------------------------------------------------------------
// buddy_page_allocator_top: buddy allocator over page frames
// Holds the registers and joins the sequencer to the frame memory.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_page_allocator_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [0:0]  csr_index,
   input  wire  [31:0] csr_wdata,
   bpa_req_if.sink     req,
   bpa_rsp_if.source   rsp
);
   logic [12:0] frames_count_ff;
   logic [31:0] region_base_ff;
   bpa_pkg::mem_req_type mreq;
   bpa_pkg::mem_rsp_type mrsp;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_count_ff <= 13'd4096;
         region_base_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == bpa_pkg::REG_FRAMES_COUNT) frames_count_ff <= csr_wdata[12:0];
         else                                         region_base_ff  <= csr_wdata;
      end
   end

   bpa_seq u_seq (
      .clock(clock), .reset(reset), .frames_count(frames_count_ff),
      .region_base(region_base_ff), .req(req), .rsp(rsp),
      .mreq(mreq), .mrsp(mrsp)
   );

   bpa_frame_mem u_mem (.clock(clock), .req(mreq), .rsp(mrsp));
endmodule
`default_nettype wire

// ===== sim/buddy_page_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_top_tb: self-checking bench for the buddy page allocator
// Drives allocate, free, initialize and unused-op items through the request
// channel in random bursts. A behavioural copy of the free lists and frame
// table predicts every response, and the response channel stalls on its own
// pattern. Several frame counts and region bases are covered, extremes included.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top_tb;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef logic [bpa_pkg::CNT_W-1:0] cnt_type;
   typedef logic [bpa_pkg::LVL_W-1:0] lvl_type;

   typedef enum logic [1:0] {PICK_PLAIN, PICK_LIVE, PICK_LAST_ALLOC} pick_kind_type;

   typedef struct {
      logic [1:0]    op;
      logic [31:0]   nbytes;
      logic [31:0]   address;
      pick_kind_type pick;
      logic [31:0]   page_off;
   } alloc_item_type;

   typedef struct {
      logic        ok;
      logic [31:0] block_address;
      logic [3:0]  blk_order;
   } alloc_result_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [31:0] csr_wdata;

   bpa_req_if req_ch ();
   bpa_rsp_if rsp_ch ();

   buddy_page_allocator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   // Shadow of the allocator state
   cnt_type      sh_frames;
   logic [31:0]  sh_base;
   cnt_type      sh_heads [bpa_pkg::LEVELS];
   lvl_type      sh_level [bpa_pkg::MAX_FRAMES];
   logic [1:0]   sh_flags [bpa_pkg::MAX_FRAMES];
   cnt_type      sh_next  [bpa_pkg::MAX_FRAMES];
   cnt_type      sh_prev  [bpa_pkg::MAX_FRAMES];

   int unsigned      live_frames[$];
   logic [31:0]      last_alloc_addr;
   alloc_item_type   pending_items[$];
   alloc_result_type expected_results[$];

   int errors;
   int n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad, n_init, n_other;

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned active_frames();
      return (sh_frames > bpa_pkg::MAX_FRAMES) ? bpa_pkg::MAX_FRAMES : int'(sh_frames);
   endfunction

   function automatic void list_push(int unsigned lvl, int unsigned idx, int unsigned cnt);
      int unsigned old;
      old = sh_heads[lvl];
      sh_flags[idx] = bpa_pkg::FL_HEAD;
      sh_level[idx] = lvl_type'(lvl);
      sh_next[idx]  = cnt_type'((old < cnt) ? old : cnt);
      sh_prev[idx]  = cnt_type'(cnt);
      if (old < cnt) sh_prev[old] = cnt_type'(idx);
      sh_heads[lvl] = cnt_type'(idx);
   endfunction

   function automatic void list_unlink(int unsigned lvl, int unsigned idx, int unsigned cnt);
      int unsigned p, n;
      p = sh_prev[idx];
      n = sh_next[idx];
      if (p >= cnt) sh_heads[lvl] = cnt_type'((n < cnt) ? n : cnt);
      else sh_next[p] = cnt_type'((n < cnt) ? n : cnt);
      if (n < cnt) sh_prev[n] = cnt_type'((p < cnt) ? p : cnt);
   endfunction

   // Carve the region into the largest aligned blocks that fit
   function automatic void build_lists(int unsigned cnt);
      int unsigned i, lvl, bsize;
      for (i = 0; i < bpa_pkg::LEVELS; i++) sh_heads[i] = cnt_type'(cnt);
      for (i = 0; i < cnt; i++) begin
         sh_flags[i] = bpa_pkg::FL_ALLOC;
         sh_level[i] = '0;
         sh_next[i]  = cnt_type'(cnt);
         sh_prev[i]  = cnt_type'(cnt);
      end
      lvl   = bpa_pkg::LEVELS - 1;
      bsize = 1 << (bpa_pkg::LEVELS - 1);
      i     = 0;
      while (i < cnt) begin
         while (i + bsize > cnt) begin
            bsize >>= 1;
            lvl--;
         end
         list_push(lvl, i, cnt);
         i += bsize;
      end
      live_frames.delete();
   endfunction

   function automatic alloc_result_type take_block(logic [31:0] bytes, int unsigned cnt);
      alloc_result_type res;
      longint unsigned pages;
      int unsigned lvl, cur, idx, buddy;
      res = '{ok: 1'b0, block_address: '0, blk_order: '0};
      pages = (longint'(bytes) + bpa_pkg::PAGE_BYTES - 1) / bpa_pkg::PAGE_BYTES;
      if (pages == 0) pages = 1;
      lvl = 0;
      while (lvl < bpa_pkg::LEVELS && (64'd1 << lvl) < pages) lvl++;
      if (lvl >= bpa_pkg::LEVELS) return res;
      cur = lvl;
      while (cur < bpa_pkg::LEVELS && sh_heads[cur] >= cnt) cur++;
      if (cur >= bpa_pkg::LEVELS) return res;
      idx = sh_heads[cur];
      list_unlink(cur, idx, cnt);
      // split down, returning upper halves to their lists
      while (cur > lvl) begin
         cur--;
         buddy = idx ^ (1 << cur);
         if (buddy < cnt) list_push(cur, buddy, cnt);
      end
      sh_flags[idx] = bpa_pkg::FL_AHEAD;
      sh_level[idx] = lvl_type'(lvl);
      sh_next[idx]  = cnt_type'(cnt);
      sh_prev[idx]  = cnt_type'(cnt);
      res.ok = 1'b1;
      res.block_address = sh_base + idx * bpa_pkg::PAGE_BYTES;
      res.blk_order = lvl_type'(lvl);
      live_frames.push_back(idx);
      last_alloc_addr = res.block_address;
      return res;
   endfunction

   function automatic alloc_result_type return_block(logic [31:0] address, int unsigned cnt);
      alloc_result_type res;
      logic [31:0] rel;
      int unsigned idx, lvl, buddy, t;
      res = '{ok: 1'b0, block_address: '0, blk_order: '0};
      rel = address - sh_base;
      idx = rel / bpa_pkg::PAGE_BYTES;
      if (idx >= cnt || sh_flags[idx] != bpa_pkg::FL_AHEAD) return res;
      foreach (live_frames[k])
         if (live_frames[k] == idx) begin
            live_frames.delete(k);
            break;
         end
      lvl = sh_level[idx];
      if (lvl > bpa_pkg::LEVELS - 1) lvl = bpa_pkg::LEVELS - 1;
      // merge upward while the buddy is a free head of the same level
      while (lvl < bpa_pkg::LEVELS - 1) begin
         buddy = idx ^ (1 << lvl);
         if (buddy >= cnt || sh_level[buddy] != lvl || sh_flags[buddy] != bpa_pkg::FL_HEAD)
            break;
         list_unlink(lvl, buddy, cnt);
         if (buddy < idx) begin
            t = buddy;
            buddy = idx;
            idx = t;
         end
         sh_flags[buddy] = bpa_pkg::FL_ALLOC;
         sh_level[buddy] = '0;
         lvl++;
      end
      list_push(lvl, idx, cnt);
      res.ok = 1'b1;
      res.blk_order = lvl_type'(lvl);
      return res;
   endfunction

   function automatic alloc_result_type predict_outcome(logic [1:0] op, logic [31:0] bytes,
                                                        logic [31:0] address);
      alloc_result_type res;
      int unsigned cnt;
      cnt = active_frames();
      res = '{ok: 1'b0, block_address: '0, blk_order: '0};
      case (op)
         bpa_pkg::OP_ALLOC: begin
            res = take_block(bytes, cnt);
            if (res.ok) n_alloc_ok++; else n_alloc_fail++;
         end
         bpa_pkg::OP_FREE: begin
            res = return_block(address, cnt);
            if (res.ok) n_free_ok++; else n_free_bad++;
         end
         bpa_pkg::OP_INIT: begin
            build_lists(cnt);
            res.ok = 1'b1;
            n_init++;
         end
         default: n_other++;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- clock, reset
   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.op = bpa_pkg::OP_ALLOC;
      req_ch.nbytes = '0;
      req_ch.address = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- driver
   logic           req_taken;
   int             burst_left, gap_left;
   alloc_item_type cur_item;
   logic [31:0]    picked_addr;

   initial begin
      req_taken  = 1'b0;
      burst_left = 0;
      gap_left   = 0;
   end

   // Predict each accepted item at the edge that takes it
   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready)
         expected_results.push_back(predict_outcome(req_ch.op, req_ch.nbytes,
                                                    req_ch.address));
   end

   // Present the next item once the current one has gone, in bursts with gaps
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            cur_item = pending_items.pop_front();
            picked_addr = cur_item.address;
            if (cur_item.pick == PICK_LIVE && live_frames.size() > 0)
               picked_addr = sh_base
                  + live_frames[$urandom_range(0, live_frames.size() - 1)]
                    * bpa_pkg::PAGE_BYTES
                  + cur_item.page_off;
            else if (cur_item.pick == PICK_LAST_ALLOC)
               picked_addr = last_alloc_addr + cur_item.page_off;
            req_ch.valid   <= 1'b1;
            req_ch.op      <= cur_item.op;
            req_ch.nbytes  <= cur_item.nbytes;
            req_ch.address <= picked_addr;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   int ready_mode, ready_run;
   initial begin
      ready_mode = 0;
      ready_run  = 0;
   end

   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_run  = $urandom_range(1, 40);
      end else begin
         ready_run--;
      end
      case (ready_mode)
         1:       rsp_ch.ready <= 1'b0;
         2:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         default: rsp_ch.ready <= 1'b1;
      endcase
   end

   // ---------------------------------------------------------------- monitor
   alloc_result_type want;
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("response with nothing outstanding: ok %0b address %h level %0d",
                   rsp_ch.ok, rsp_ch.block_address, rsp_ch.blk_order);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.ok !== want.ok) begin
               $error("ok mismatch: expected %0b, actual %0b", want.ok, rsp_ch.ok);
               errors++;
            end
            if (rsp_ch.block_address !== want.block_address) begin
               $error("block_address mismatch: expected %h, actual %h",
                      want.block_address, rsp_ch.block_address);
               errors++;
            end
            if (rsp_ch.blk_order !== want.blk_order) begin
               $error("blk_order mismatch: expected %0d, actual %0d",
                      want.blk_order, rsp_ch.blk_order);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic alloc_item_type make_item(logic [1:0] op, logic [31:0] bytes,
                                                logic [31:0] address, pick_kind_type pick,
                                                logic [31:0] page_off);
      alloc_item_type it;
      it.op = op;
      it.nbytes = bytes;
      it.address = address;
      it.pick = pick;
      it.page_off = page_off;
      return it;
   endfunction

   function automatic logic [31:0] size_for_level(int unsigned lvl);
      if (lvl == 0) return $urandom_range(0, bpa_pkg::PAGE_BYTES);
      return (bpa_pkg::PAGE_BYTES << lvl)
             - $urandom_range(0, (bpa_pkg::PAGE_BYTES << (lvl - 1)) - 1);
   endfunction

   // Mostly allocate and free of live blocks; the rest is noise and rebuilds
   function automatic alloc_item_type random_item();
      int unsigned r, s;
      logic [31:0] off;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         s = $urandom_range(0, 9);
         if (s == 0) return make_item(bpa_pkg::OP_ALLOC, 32'd0, $urandom, PICK_PLAIN, 0);
         if (s == 1) return make_item(bpa_pkg::OP_ALLOC, $urandom, $urandom, PICK_PLAIN, 0);
         return make_item(bpa_pkg::OP_ALLOC,
                          size_for_level($urandom_range(0, (s > 7) ? 10 : 3)),
                          $urandom, PICK_PLAIN, 0);
      end
      if (r < 80) begin
         off = ($urandom_range(0, 4) == 0) ? $urandom_range(0, bpa_pkg::PAGE_BYTES - 1) : 0;
         if ($urandom_range(0, 15) == 0) off += bpa_pkg::PAGE_BYTES;
         return make_item(bpa_pkg::OP_FREE, $urandom, $urandom, PICK_LIVE, off);
      end
      if (r < 95) begin
         if ($urandom_range(0, 1) == 0)
            return make_item(bpa_pkg::OP_FREE, $urandom, $urandom, PICK_PLAIN, 0);
         return make_item(bpa_pkg::OP_FREE, $urandom, $urandom, PICK_LAST_ALLOC,
                          $urandom_range(0, 1) * bpa_pkg::PAGE_BYTES);
      end
      if (r < 97) return make_item(bpa_pkg::OP_INIT, $urandom, $urandom, PICK_PLAIN, 0);
      return make_item(OP_NONE, $urandom, $urandom, PICK_PLAIN, 0);
   endfunction

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_ch.valid || expected_results.size() > 0)
         @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == bpa_pkg::REG_FRAMES_COUNT) sh_frames = value[bpa_pkg::CNT_W-1:0];
      else sh_base = value;
      @(negedge clock);
   endtask

   task automatic run_phase(logic [31:0] frames, logic [31:0] base, bit rebuild, int count);
      wait_idle();
      write_reg(bpa_pkg::REG_FRAMES_COUNT, frames);
      write_reg(bpa_pkg::REG_REGION_BASE, base);
      if (rebuild) pending_items.push_back(make_item(bpa_pkg::OP_INIT, 0, 0, PICK_PLAIN, 0));
      repeat (count) pending_items.push_back(random_item());
   endtask

   initial begin
      errors = 0;
      n_alloc_ok = 0; n_alloc_fail = 0; n_free_ok = 0; n_free_bad = 0;
      n_init = 0; n_other = 0;
      sh_frames = cnt_type'(bpa_pkg::MAX_FRAMES);
      sh_base = '0;
      last_alloc_addr = '0;
      for (int i = 0; i < bpa_pkg::LEVELS; i++) sh_heads[i] = cnt_type'(bpa_pkg::MAX_FRAMES);
      @(negedge reset);
      @(negedge clock);

      // Directed: empty lists, unused op, size extremes, bad and good frees
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'd0, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_INIT, 32'd0, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'd0, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'd1, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'd4096, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'd4097, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'h0040_0000, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'h0040_0001, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_ALLOC, 32'd8192, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 0, PICK_LAST_ALLOC,
                                        bpa_pkg::PAGE_BYTES));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 0, PICK_LAST_ALLOC, 32'hFFF));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 0, PICK_LAST_ALLOC, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 32'd0, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 32'hFFFF_F000, PICK_PLAIN, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 0, PICK_LIVE, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 0, PICK_LIVE, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 0, PICK_LIVE, 0));
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 0, PICK_LIVE, 0));

      // Oversized count, high base; an address below the base must wrap out
      run_phase(32'h1FFF, 32'h8000_0000, 1'b1, 0);
      pending_items.push_back(make_item(bpa_pkg::OP_FREE, 0, 32'h0000_1000, PICK_PLAIN, 0));
      repeat (400) pending_items.push_back(random_item());
      run_phase(32'd1, 32'hFFFF_F000, 1'b1, 100);
      run_phase(32'd0, $urandom & 32'hFFFF_F000, 1'b1, 40);
      run_phase(32'd1000, $urandom & 32'hFFFF_F000, 1'b1, 500);
      // Shrink the count without a rebuild
      run_phase(32'd600, $urandom & 32'hFFFF_F000, 1'b0, 300);
      run_phase(32'd4096, 32'd0, 1'b1, 600);

      wait_idle();
      $display("Ran %0d allocates (%0d refused), %0d frees (%0d rejected), %0d rebuilds,",
               n_alloc_ok + n_alloc_fail, n_alloc_fail, n_free_ok + n_free_bad,
               n_free_bad, n_init);
      $display("and %0d unused ops over six frame-count and base settings.", n_other);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #60_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
